// File: design/sccb_register_master_top_assert.svh
// Assertion macros for the SCCB register master.
// Included by the top level; the caller's scope must provide i_clk and i_rst_n.
`ifndef SCCB_REGISTER_MASTER_TOP_ASSERT_SVH
`define SCCB_REGISTER_MASTER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SRM_ASSERT_RUN(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sccb_register_master: assertion failed");

// Check a property on every clock edge, reset included.
`define SRM_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("sccb_register_master: assertion failed");

`endif

// File: design/srm_pkg.sv
// Shared types and constants for the SCCB register master.
// No dependencies; imported by sccb_register_master_top.
package srm_pkg;

    localparam int TICK_CNT_W_DEFAULT = 24;

    localparam int DEV_ID_W = 8;
    localparam int HALF_W   = 16;
    localparam int GAP_W    = 24;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int MASK_W   = 3;
    localparam int BIT_IDX_W = 4;
    localparam int SLOT_W   = 2;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [DEV_ID_W-1:0] DEV_ID_RESET = 8'h42;
    localparam logic [HALF_W-1:0]   HALF_RESET   = 16'd10;
    localparam logic [GAP_W-1:0]    GAP_RESET    = 24'd10000;
    localparam logic [DEV_ID_W-1:0] READ_BIT     = 8'h01;

    // Request kinds carried by each tick.
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEV_ID = 2'd0;
    localparam logic [1:0] REG_HALF   = 2'd1;
    localparam logic [1:0] REG_GAP    = 2'd2;

    // Byte slots of a transfer.
    localparam logic [SLOT_W-1:0] SLOT_ID   = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_ADDR = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_DATA = 2'd2;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = 4'd7;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_HIGH = 5'd1,
        PH_ST_FALL = 5'd2,
        PH_TX_LOW  = 5'd3,
        PH_TX_HIGH = 5'd4,
        PH_AK_LOW  = 5'd5,
        PH_AK_HIGH = 5'd6,
        PH_RS_LOW  = 5'd7,
        PH_RX_LOW  = 5'd8,
        PH_RX_HIGH = 5'd9,
        PH_NK_LOW  = 5'd10,
        PH_NK_HIGH = 5'd11,
        PH_SP_LOW  = 5'd12,
        PH_SP_HIGH = 5'd13,
        PH_SP_RISE = 5'd14,
        PH_GAP     = 5'd15
    } t_phase;

endpackage

// File: design/sccb_register_master_top.sv
// SCCB register master top level: tick-driven bus sequencer with APB config.
// Depends on srm_pkg and sccb_register_master_top_assert.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready): one word per bus tick. i_kind
//   selects tick only, write request or read request; a request is taken
//   only while the master is idle, otherwise the word counts as a plain
//   tick. i_sda_in carries the sampled data line for that tick.
//   Output channel (o_out_valid / i_out_ready): exactly one result word per
//   accepted input word, showing the line drive, busy/done flags, the last
//   received byte and the acknowledge mask after that tick.
//   A result is registered and appears in the cycle after its word is accepted.
//   Throughput: one word per cycle unless the output stalls; the whole bus step
//   for a tick is a single pass from the state registers to the result register.
//   Stall: the result register holds its word while i_out_ready is low; a
//   new input word is taken in the same cycle the held result leaves, so the
//   channels stay full back to back.
//   Configuration: APB registers at byte addresses 0 (device write id),
//   4 (half period ticks) and 8 (stop gap ticks); pready is always high.
//   Write only while the master is idle.
//   Reset (synchronous, active low): bus state goes idle, shift registers and
//   the mask clear, configuration returns to id 0x42, half period 10 and
//   stop gap 10000, and the output register empties.
module sccb_register_master_top #(
    parameter int TICK_COUNTER_WIDTH = srm_pkg::TICK_CNT_W_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [srm_pkg::APB_AW-1:0]        paddr,
    input  logic [srm_pkg::APB_DW-1:0]        pwdata,
    output logic [srm_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [srm_pkg::KIND_W-1:0]        i_kind,
    input  logic [srm_pkg::BYTE_W-1:0]        i_reg_address,
    input  logic [srm_pkg::BYTE_W-1:0]        i_write_data,
    input  logic                              i_sda_in,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_scl_level,
    output logic                              o_scl_enable,
    output logic                              o_sda_level,
    output logic                              o_sda_enable,
    output logic                              o_busy_res,
    output logic                              o_done_res,
    output logic [srm_pkg::BYTE_W-1:0]        o_read_data,
    output logic [srm_pkg::MASK_W-1:0]        o_nack_mask
);
    import srm_pkg::*;

    // Compare width wide enough for both the tick counter and the gap register.
    localparam int CW  = (TICK_COUNTER_WIDTH > GAP_W) ? TICK_COUNTER_WIDTH : GAP_W;
    localparam int CWP = CW + 1;
    localparam logic [CW:0] CNT_MAX = CWP'({TICK_COUNTER_WIDTH{1'b1}});

    // Configuration registers.
    logic [DEV_ID_W-1:0] r_dev_id;
    logic [HALF_W-1:0]   r_half;
    logic [GAP_W-1:0]    r_gap;

    // Bus state.
    t_phase                        r_phase, n_phase;
    logic [SLOT_W-1:0]             r_slot, n_slot;
    logic [BIT_IDX_W-1:0]          r_bit_index, n_bit_index;
    logic [TICK_COUNTER_WIDTH-1:0] r_tick, n_tick;
    logic [BYTE_W-1:0]             r_send, n_send;
    logic [BYTE_W-1:0]             r_recv, n_recv;
    logic [BYTE_W-1:0]             r_addr, n_addr;
    logic [BYTE_W-1:0]             r_data, n_data;
    logic                          r_is_read, n_is_read;
    logic [MASK_W-1:0]             r_ack, n_ack;

    // Result register.
    logic r_out_valid;
    logic r_scl_l, r_scl_e, r_sda_l, r_sda_e, r_busy, r_done;
    logic [BYTE_W-1:0] r_rd;
    logic [MASK_W-1:0] r_mask;

    logic n_scl_l, n_scl_e, n_sda_l, n_sda_e, n_busy, n_done;
    logic in_acc;
    logic cfg_wr;
    logic [CW:0] tick_inc;
    logic [CW:0] step_len;
    logic [CW:0] gap_len;

    // Take a new word whenever the result register is empty or draining.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_DEV_ID: prdata = APB_DW'(r_dev_id);
            REG_HALF:   prdata = APB_DW'(r_half);
            REG_GAP:    prdata = APB_DW'(r_gap);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_id <= DEV_ID_RESET;
            r_half   <= HALF_RESET;
            r_gap    <= GAP_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_DEV_ID: r_dev_id <= pwdata[DEV_ID_W-1:0];
                REG_HALF:   r_half   <= pwdata[HALF_W-1:0];
                REG_GAP:    r_gap    <= pwdata[GAP_W-1:0];
                default:    ;
            endcase
        end
    end

    // Step length: a zero half period counts as one tick. The gap is clamped
    // to what the tick counter can hold.
    assign tick_inc = CWP'(r_tick) + 1'b1;
    assign step_len = (r_half == '0) ? CWP'(1) : CWP'(r_half);
    assign gap_len  = (CWP'(r_gap) > CNT_MAX) ? CNT_MAX : CWP'(r_gap);

    // Next bus state for one tick.
    always_comb begin
        n_phase     = r_phase;
        n_slot      = r_slot;
        n_bit_index = r_bit_index;
        n_tick      = r_tick;
        n_send      = r_send;
        n_recv      = r_recv;
        n_addr      = r_addr;
        n_data      = r_data;
        n_is_read   = r_is_read;
        n_ack       = r_ack;
        n_done      = 1'b0;

        if (r_phase == PH_IDLE) begin
            // Latch a request and start the transfer.
            if (i_kind == KIND_WRITE || i_kind == KIND_READ) begin
                n_is_read   = (i_kind == KIND_READ);
                n_addr      = i_reg_address;
                n_data      = i_write_data;
                n_send      = r_dev_id;
                n_ack       = '0;
                n_slot      = SLOT_ID;
                n_bit_index = '0;
                n_phase     = PH_ST_HIGH;
                n_tick      = '0;
            end
        end else if (r_phase == PH_GAP) begin
            if (tick_inc < gap_len) begin
                n_tick = r_tick + 1'b1;
            end else begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        end else if (tick_inc < step_len) begin
            n_tick = r_tick + 1'b1;
        end else begin
            // Step ends: advance to the next bus phase.
            n_tick = '0;
            case (r_phase)
                PH_ST_HIGH: n_phase = PH_ST_FALL;
                PH_ST_FALL: begin
                    n_bit_index = '0;
                    n_phase     = PH_TX_LOW;
                end
                PH_TX_LOW: n_phase = PH_TX_HIGH;
                PH_TX_HIGH: begin
                    if (r_bit_index >= LAST_BIT) begin
                        n_phase = PH_AK_LOW;
                    end else begin
                        n_bit_index = r_bit_index + 1'b1;
                        n_send      = {r_send[BYTE_W-2:0], 1'b0};
                        n_phase     = PH_TX_LOW;
                    end
                end
                PH_AK_LOW: n_phase = PH_AK_HIGH;
                PH_AK_HIGH: begin
                    // Record a missing acknowledge and carry on regardless.
                    if (i_sda_in) begin
                        case (r_slot)
                            SLOT_ID:   n_ack = r_ack | 3'b001;
                            SLOT_ADDR: n_ack = r_ack | 3'b010;
                            SLOT_DATA: n_ack = r_ack | 3'b100;
                            default:   n_ack = r_ack;
                        endcase
                    end
                    case (r_slot)
                        SLOT_ID: begin
                            n_slot      = SLOT_ADDR;
                            n_send      = r_addr;
                            n_bit_index = '0;
                            n_phase     = PH_TX_LOW;
                        end
                        SLOT_ADDR: begin
                            n_slot      = SLOT_DATA;
                            n_bit_index = '0;
                            if (r_is_read) begin
                                n_send  = r_dev_id | READ_BIT;
                                n_phase = PH_RS_LOW;
                            end else begin
                                n_send  = r_data;
                                n_phase = PH_TX_LOW;
                            end
                        end
                        SLOT_DATA: begin
                            if (r_is_read) begin
                                n_bit_index = '0;
                                n_phase     = PH_RX_LOW;
                            end else begin
                                n_phase = PH_SP_LOW;
                            end
                        end
                        default: n_phase = PH_SP_LOW;
                    endcase
                end
                PH_RS_LOW: n_phase = PH_ST_HIGH;
                PH_RX_LOW: n_phase = PH_RX_HIGH;
                PH_RX_HIGH: begin
                    n_recv = {r_recv[BYTE_W-2:0], i_sda_in};
                    if (r_bit_index >= LAST_BIT) begin
                        n_phase = PH_NK_LOW;
                    end else begin
                        n_bit_index = r_bit_index + 1'b1;
                        n_phase     = PH_RX_LOW;
                    end
                end
                PH_NK_LOW:  n_phase = PH_NK_HIGH;
                PH_NK_HIGH: n_phase = PH_SP_LOW;
                PH_SP_LOW:  n_phase = PH_SP_HIGH;
                PH_SP_HIGH: n_phase = PH_SP_RISE;
                PH_SP_RISE: begin
                    n_phase = (r_gap == '0) ? PH_IDLE : PH_GAP;
                    n_done  = 1'b1;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Line drive for the phase after this tick; released lines read high.
    always_comb begin
        n_scl_l = 1'b1;
        n_scl_e = 1'b0;
        n_sda_l = 1'b1;
        n_sda_e = 1'b0;
        n_busy  = 1'b1;
        case (n_phase)
            PH_IDLE:    n_busy = 1'b0;
            PH_GAP:     ;
            PH_ST_HIGH: begin
                n_scl_e = 1'b1;
                n_sda_e = 1'b1;
            end
            PH_ST_FALL: begin
                n_scl_e = 1'b1;
                n_sda_e = 1'b1;
                n_sda_l = 1'b0;
            end
            PH_TX_LOW: begin
                n_scl_e = 1'b1;
                n_scl_l = 1'b0;
                n_sda_e = 1'b1;
                n_sda_l = n_send[BYTE_W-1];
            end
            PH_TX_HIGH: begin
                n_scl_e = 1'b1;
                n_sda_e = 1'b1;
                n_sda_l = n_send[BYTE_W-1];
            end
            PH_AK_LOW, PH_RX_LOW: begin
                n_scl_e = 1'b1;
                n_scl_l = 1'b0;
            end
            PH_AK_HIGH, PH_RX_HIGH: n_scl_e = 1'b1;
            PH_RS_LOW, PH_NK_LOW: begin
                n_scl_e = 1'b1;
                n_scl_l = 1'b0;
                n_sda_e = 1'b1;
            end
            PH_NK_HIGH, PH_SP_RISE: begin
                n_scl_e = 1'b1;
                n_sda_e = 1'b1;
            end
            PH_SP_LOW: begin
                n_scl_e = 1'b1;
                n_scl_l = 1'b0;
                n_sda_e = 1'b1;
                n_sda_l = 1'b0;
            end
            PH_SP_HIGH: begin
                n_scl_e = 1'b1;
                n_sda_e = 1'b1;
                n_sda_l = 1'b0;
            end
            default: n_busy = 1'b0;
        endcase
    end

    // Advance the bus state only on accepted words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_slot      <= '0;
            r_bit_index <= '0;
            r_tick      <= '0;
            r_send      <= '0;
            r_recv      <= '0;
            r_addr      <= '0;
            r_data      <= '0;
            r_is_read   <= 1'b0;
            r_ack       <= '0;
        end else if (in_acc) begin
            r_phase     <= n_phase;
            r_slot      <= n_slot;
            r_bit_index <= n_bit_index;
            r_tick      <= n_tick;
            r_send      <= n_send;
            r_recv      <= n_recv;
            r_addr      <= n_addr;
            r_data      <= n_data;
            r_is_read   <= n_is_read;
            r_ack       <= n_ack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: load with the word, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_scl_l <= n_scl_l;
            r_scl_e <= n_scl_e;
            r_sda_l <= n_sda_l;
            r_sda_e <= n_sda_e;
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_rd    <= n_recv;
            r_mask  <= n_ack;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scl_level  = r_scl_l;
    assign o_scl_enable = r_scl_e;
    assign o_sda_level  = r_sda_l;
    assign o_sda_enable = r_sda_e;
    assign o_busy_res   = r_busy;
    assign o_done_res   = r_done;
    assign o_read_data  = r_rd;
    assign o_nack_mask  = r_mask;

`include "sccb_register_master_top_assert.svh"

    // A finished stop always leaves both lines released.
    `SRM_ASSERT_RUN(a_done_released, (o_out_valid && o_done_res) |-> (!o_scl_enable && !o_sda_enable))
    // An idle master shows both lines at the pulled-up level.
    `SRM_ASSERT_RUN(a_idle_high, (o_out_valid && !o_busy_res) |-> (o_scl_level && o_sda_level))
    // A write request taken while idle starts a transfer with a clear mask.
    `SRM_ASSERT_RUN(a_req_start, (in_acc && r_phase == PH_IDLE && i_kind == KIND_WRITE) |=> (r_phase == PH_ST_HIGH && r_ack == '0))
    // The bit counter never runs past the last bit of a byte.
    `SRM_ASSERT_RUN(a_bit_range, r_bit_index <= LAST_BIT)

endmodule
